@@ hdl/wfba_pkg.sv @@
`default_nettype none
package wfba_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
	localparam int CNT_BITS   = 7;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef struct packed {
		logic        action;
		logic [5:0]  block_number;
		logic [15:0] size_value;
	} wfba_in_t;

	typedef struct packed {
		logic        granted;
		logic [5:0]  chosen_block;
		logic [15:0] leftover;
	} wfba_out_t;

	typedef struct packed {
		logic load;
		logic begin_req;
		logic issue;
		logic finish;
	} wfba_cmd_t;

	typedef struct packed {
		logic limit_zero;
		logic last_issue;
	} wfba_sts_t;

endpackage
`default_nettype wire

@@ hdl/wfba_ram.sv @@
`default_nettype none
module wfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/wfba_ctrl.sv @@
`default_nettype none
module wfba_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                action,
	input  wire wfba_pkg::wfba_sts_t sts,
	output logic                     busy,
	output wfba_pkg::wfba_cmd_t      cmd
);
	import wfba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load      = start && (action == ACT_LOAD);
				cmd.begin_req = start && (action == ACT_REQUEST);
			end
			ST_SCAN:   cmd.issue  = 1'b1;
			ST_WAIT:   cmd        = '0;
			ST_FINISH: cmd.finish = 1'b1;
			default:   cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && (action == ACT_REQUEST)) begin
						state_q <= sts.limit_zero ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.last_issue) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT:   state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/wfba_datapath.sv @@
`default_nettype none
module wfba_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire wfba_pkg::cnt_t       cfg_wdata,
	input  wire wfba_pkg::wfba_in_t   req,
	input  wire wfba_pkg::wfba_cmd_t  cmd,
	output wfba_pkg::wfba_sts_t       sts,
	output logic                      done,
	output wfba_pkg::wfba_out_t       result
);
	import wfba_pkg::*;

	cnt_t              count_q;
	cnt_t              limit;
	logic [NUM_BLOCKS-1:0] used_q;
	idx_t              addr_q;
	size_t             want_q;
	logic              valid_s1;
	idx_t              idx_s1;
	logic              used_s1;
	size_t             rd_data;
	logic              found_q;
	idx_t              best_idx_q;
	size_t             best_left_q;
	logic              fit;
	size_t             left;
	logic              load_ok;

	// entries past the table take no part in a scan
	assign limit = (count_q > cnt_t'(NUM_BLOCKS)) ? cnt_t'(NUM_BLOCKS) : count_q;

	assign sts.limit_zero = (limit == '0);
	assign sts.last_issue = ((cnt_t'(addr_q) + cnt_t'(1)) == limit);

	assign load_ok = (int'(req.block_number) < NUM_BLOCKS);

	wfba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_sizes (
		.clk   (clk),
		.we    (cmd.load && load_ok),
		.waddr (idx_t'(req.block_number)),
		.wdata (size_t'(req.size_value)),
		.re    (cmd.issue),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	assign fit  = valid_s1 && !used_s1 && (rd_data >= want_q);
	assign left = rd_data - want_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			used_q   <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			done     <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.load && load_ok) begin
				used_q[idx_t'(req.block_number)] <= 1'b0;
			end
			valid_s1 <= cmd.issue;
			done     <= cmd.finish;
			if (cmd.begin_req) begin
				found_q <= 1'b0;
			end else if (fit && (!found_q || (left > best_left_q))) begin
				// strict compare keeps the lowest index on a tie
				found_q <= 1'b1;
			end
			if (cmd.finish && found_q) begin
				used_q[best_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_req) begin
			want_q <= size_t'(req.size_value);
			addr_q <= '0;
		end else if (cmd.issue) begin
			addr_q <= addr_q + idx_t'(1);
		end
		idx_s1  <= addr_q;
		used_s1 <= used_q[addr_q];
		if (!cmd.begin_req && fit && (!found_q || (left > best_left_q))) begin
			best_idx_q  <= idx_s1;
			best_left_q <= left;
		end
		if (cmd.finish) begin
			result.granted      <= found_q;
			result.chosen_block <= found_q ? 6'(best_idx_q) : '0;
			result.leftover     <= found_q ? 16'(best_left_q) : '0;
		end
	end

endmodule
`default_nettype wire

@@ hdl/worst_fit_block_allocator_unit.sv @@
`default_nettype none
// Worst-fit allocator over a table of NUM_BLOCKS block sizes. A load word (no result)
// writes one entry's size and frees it. A request word scans the free entries among
// the first block_count, one entry per cycle through the single read port of the size
// memory, and picks the largest leftover (lowest index on a tie).
// Busy is high from the accepting edge through the scan of min(block_count, NUM_BLOCKS)
// entries, a wait state and a finish state (the finish state alone when block_count is
// zero); the result word shows with done for exactly one cycle right after busy falls, and
// a new start is taken in that same cycle. The receiver cannot stall, so every result must
// be taken when done is high. block_count may be written only while busy is low.
module worst_fit_block_allocator_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire wfba_pkg::wfba_in_t req,
	input  wire logic               cfg_we,
	input  wire wfba_pkg::cnt_t     cfg_wdata,
	output logic                    done,
	output wfba_pkg::wfba_out_t     result
);
	import wfba_pkg::*;

	wfba_cmd_t cmd;
	wfba_sts_t sts;

	wfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (req.action),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	wfba_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import wfba_pkg::*;

	localparam int ITEMS = 1200;

	class worst_fit_shadow;
		size_t     sizes [NUM_BLOCKS];
		bit        used [NUM_BLOCKS];
		cnt_t      count;
		wfba_out_t grants_due [$];
		int        errors;

		function int scan_len();
			return (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
		endfunction

		// update the shadow table for an accepted word, queue the grant a request earns
		function void take_word(wfba_in_t w);
			wfba_out_t g;
			size_t     left;
			int        n;
			if (w.action == ACT_LOAD) begin
				sizes[w.block_number] = w.size_value;
				used[w.block_number] = 1'b0;
				return;
			end
			g = '0;
			n = scan_len();
			for (int j = 0; j < n; j++) begin
				if (!used[j] && sizes[j] >= w.size_value) begin
					left = sizes[j] - w.size_value;
					// strict compare keeps the lowest index on a tie
					if (!g.granted || left > g.leftover) begin
						g.granted = 1'b1;
						g.chosen_block = idx_t'(j);
						g.leftover = left;
					end
				end
			end
			if (g.granted)
				used[g.chosen_block] = 1'b1;
			grants_due.push_back(g);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_grant(wfba_out_t r);
			wfba_out_t e;
			if (grants_due.size() == 0) begin
				report($sformatf("result word with nothing pending: %h", r));
				return;
			end
			e = grants_due.pop_front();
			if (r.granted !== e.granted)
				report($sformatf("granted %b, expected %b", r.granted, e.granted));
			if (r.chosen_block !== e.chosen_block)
				report($sformatf("chosen_block %0d, expected %0d", r.chosen_block,
					e.chosen_block));
			if (r.leftover !== e.leftover)
				report($sformatf("leftover %h, expected %h", r.leftover, e.leftover));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	wfba_in_t  req;
	logic      cfg_we;
	cnt_t      cfg_wdata;
	logic      done;
	wfba_out_t result;

	worst_fit_shadow shadow;
	bit              loaded [NUM_BLOCKS];
	bit              start_on;
	bit              quiet;
	bit              no_gaps;
	int              sent;

	worst_fit_block_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result first: a new word may be taken in the cycle its predecessor's result shows
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.check_grant(result);
			if (start && !busy)
				shadow.take_word(req);
		end
	end

	task automatic drop_start();
		if (start_on) begin
			start <= 1'b0;
			start_on = 1'b0;
		end
	endtask

	task automatic send_word(input logic action, input idx_t bn, input size_t sz);
		wfba_in_t w;
		w.action = action;
		w.block_number = bn;
		w.size_value = sz;
		req <= w;
		if (!start_on) begin
			start <= 1'b1;
			start_on = 1'b1;
		end
		do @(posedge clk); while (busy);
		sent++;
		if (action == ACT_LOAD)
			loaded[bn] = 1'b1;
	endtask

	task automatic sender_gap();
		if (!quiet && !no_gaps && $urandom_range(0, 3) == 0) begin
			drop_start();
			if ($urandom_range(0, 1) == 1) begin
				// let the scan finish, then idle on the far side of it
				@(posedge clk);
				while (busy) @(posedge clk);
				repeat ($urandom_range(0, 7)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	function automatic size_t load_size();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return size_t'($urandom_range(0, 255));
			default: return size_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic size_t request_size();
		int n;
		n = shadow.scan_len();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return size_t'($urandom_range(0, 255));
			3, 4: begin
				if (n > 0)
					return shadow.sizes[$urandom_range(0, n - 1)];
				return size_t'($urandom_range(0, 65535));
			end
			5: begin
				if (n > 0)
					return shadow.sizes[$urandom_range(0, n - 1)] >> 1;
				return '0;
			end
			default: return size_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// every entry a scan can reach gets a size before any request reaches it
	task automatic fill_table();
		for (int i = 0; i < shadow.scan_len(); i++) begin
			if (!loaded[i]) begin
				send_word(ACT_LOAD, idx_t'(i), load_size());
				sender_gap();
			end
		end
	endtask

	task automatic write_count(input cnt_t v);
		drop_start();
		@(posedge clk);
		while (shadow.grants_due.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.count = v;
		fill_table();
	endtask

	task automatic random_word();
		int   n;
		idx_t bn;
		n = shadow.scan_len();
		if ($urandom_range(0, 1) == 0) begin
			if (n > 0 && $urandom_range(0, 3) != 0)
				bn = idx_t'($urandom_range(0, n - 1));
			else
				bn = idx_t'($urandom_range(0, NUM_BLOCKS - 1));
			send_word(ACT_LOAD, bn, load_size());
		end else begin
			send_word(ACT_REQUEST, idx_t'($urandom_range(0, NUM_BLOCKS - 1)), request_size());
		end
	endtask

	initial begin
		int   len;
		cnt_t v;
		shadow = new();
		start_on = 1'b0;
		quiet = 1'b0;
		no_gaps = 1'b0;
		sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count is zero out of reset: nothing is scanned
		send_word(ACT_REQUEST, '0, '0);
		sender_gap();
		send_word(ACT_LOAD, 6'd0, 16'd100);
		send_word(ACT_LOAD, 6'd1, 16'd300);
		send_word(ACT_LOAD, 6'd2, 16'd300);
		sender_gap();
		send_word(ACT_LOAD, 6'd3, 16'd50);
		send_word(ACT_LOAD, '1, '1);
		write_count(7'd4);
		// exact fit with a tie, lowest index wins
		send_word(ACT_REQUEST, '0, 16'd300);
		send_word(ACT_REQUEST, '1, 16'd0);
		sender_gap();
		send_word(ACT_REQUEST, '0, 16'd100);
		// no fit leaves the table alone
		send_word(ACT_REQUEST, '0, 16'd60);
		send_word(ACT_REQUEST, '0, 16'd50);
		sender_gap();
		send_word(ACT_REQUEST, '0, 16'd0);
		// reload of a used entry frees it
		send_word(ACT_LOAD, 6'd1, '1);
		send_word(ACT_REQUEST, '0, '1);
		send_word(ACT_LOAD, 6'd3, '0);
		send_word(ACT_REQUEST, '0, '0);
		write_count(7'd64);
		send_word(ACT_REQUEST, '0, '0);
		send_word(ACT_REQUEST, '0, 16'd1);
		// count past the table scans the whole table
		write_count('1);
		send_word(ACT_REQUEST, '1, '0);
		sender_gap();
		send_word(ACT_REQUEST, '0, size_t'($urandom_range(0, 65535)));

		while (sent < ITEMS) begin
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = 7'd64;
				2: v = '1;
				3: v = cnt_t'($urandom_range(65, 126));
				4: v = cnt_t'($urandom_range(13, 63));
				default: v = cnt_t'($urandom_range(1, 12));
			endcase
			write_count(v);
			no_gaps = ($urandom_range(0, 3) == 0);
			len = $urandom_range(20, 80);
			repeat (len) begin
				quiet = (sent > ITEMS * 85 / 100);
				random_word();
				sender_gap();
			end
		end

		drop_start();
		@(posedge clk);
		while (shadow.grants_due.size() != 0) @(posedge clk);
		repeat (NUM_BLOCKS + 8) @(posedge clk);
		if (shadow.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
